@@ design/kett_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kett_pkg
// Shared types and codes for the keyed expiry timer table.
// ----------------------------------------------------------------------------
package kett_pkg;

    localparam int SLOT_W = 6;
    localparam int KEY_W  = 8;
    localparam int TIME_W = 32;

    // operation codes
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_SWEEP = 2'd1;
    localparam logic [1:0] FUNC_LIST  = 2'd2;

    // result codes
    localparam logic [2:0] EV_ADDED    = 3'd0;
    localparam logic [2:0] EV_EXTENDED = 3'd1;
    localparam logic [2:0] EV_KEPT     = 3'd2;
    localparam logic [2:0] EV_FULL     = 3'd3;
    localparam logic [2:0] EV_EXPIRED  = 3'd4;
    localparam logic [2:0] EV_ACTIVE   = 3'd5;
    localparam logic [2:0] EV_END      = 3'd6;

    typedef struct packed {
        logic [1:0]        func;
        logic [KEY_W-1:0]  timer_key;
        logic              timer_kind;
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] now_time;
    } req_t;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [SLOT_W-1:0] slot_index;
        logic [KEY_W-1:0]  entry_key;
        logic              entry_kind;
        logic              any_expired;
        logic              last;
    } rsp_t;

    // one slot as held in the slot RAM
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              kind;
        logic [TIME_W-1:0] expiry;
    } slot_entry_t;

endpackage

`default_nettype wire

@@ design/kett_slot_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kett_slot_ram
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kett_slot_ram
    import kett_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      slot_entry_t       rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire slot_entry_t       wr_data
);

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ design/keyed_expiry_timer_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_expiry_timer_table_core
// Table of keyed timer slots with add, sweep-expired and list operations.
// ----------------------------------------------------------------------------
// Every add, sweep or list walks the slot RAM through its single read port,
// one slot per cycle unless a result that cannot be placed in the output
// register holds the walk. An add stops its walk early when it finds its key.
// An item with the unused operation code gives no result and starts no walk.
// Valid bits live in flip-flops and clear at reset; key, kind and expiry live
// in the RAM and are used only for valid slots. A result sits in an output
// register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module keyed_expiry_timer_table_core
    import kett_pkg::*;
#(
    parameter int TIMER_SLOTS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output      logic req_ready,
    input  wire req_t req,
    output      logic rsp_valid,
    input  wire logic rsp_ready,
    output      rsp_t rsp
);

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TIMER_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_END  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   any_exp_reg, any_exp_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    // item held for the walk
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              kind_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] target_reg;

    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    slot_entry_t       ram_rd_data;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    slot_entry_t       ram_wr_data;

    logic req_fire;
    logic load_ok;
    logic slot_vld;
    logic hit;
    logic later;
    logic expired;
    logic emit;
    logic done;
    rsp_t emit_rsp;

    kett_slot_ram #(
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign load_ok   = !rsp_valid_reg || rsp_ready;

    assign slot_vld = chk_vld_reg && valid_reg[chk_idx_reg];
    assign hit      = slot_vld && (ram_rd_data.key == key_reg);
    assign later    = ram_rd_data.expiry < target_reg;
    assign expired  = slot_vld && (ram_rd_data.expiry < now_reg);

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg     <= req.func;
            key_reg    <= req.timer_key;
            kind_reg   <= req.timer_kind;
            now_reg    <= req.now_time;
            target_reg <= req.now_time + req.duration;
        end
    end

    // what the slot under check reports, if anything
    always_comb
    begin
        emit     = 1'b0;
        done     = 1'b0;
        emit_rsp = '{event_res:   EV_ACTIVE,
                     slot_index:  SLOT_W'(chk_idx_reg),
                     entry_key:   ram_rd_data.key,
                     entry_kind:  ram_rd_data.kind,
                     any_expired: 1'b0,
                     last:        1'b0};
        case (op_reg)
            FUNC_ADD:
            begin
                if (hit)
                begin
                    emit               = 1'b1;
                    done               = 1'b1;
                    emit_rsp.event_res = later ? EV_EXTENDED : EV_KEPT;
                    emit_rsp.last      = 1'b1;
                end
            end
            FUNC_SWEEP:
            begin
                if (expired)
                begin
                    emit               = 1'b1;
                    emit_rsp.event_res = EV_EXPIRED;
                end
            end
            FUNC_LIST:
            begin
                emit = slot_vld;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        any_exp_next    = any_exp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = rd_idx_reg[IDX_W-1:0];
        ram_wr_en       = 1'b0;
        ram_wr_addr     = chk_idx_reg;
        ram_wr_data     = '{key: ram_rd_data.key, kind: ram_rd_data.kind,
                            expiry: target_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.func inside {FUNC_ADD, FUNC_SWEEP, FUNC_LIST}))
                begin
                    state_next      = S_SCAN;
                    rd_idx_next     = '0;
                    chk_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    any_exp_next    = 1'b0;
                end
            end
            S_SCAN:
            begin
                // a result that cannot be placed holds the walk, RAM data included
                if (!(emit && !load_ok))
                begin
                    if (emit)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = emit_rsp;
                    end
                    if (op_reg == FUNC_ADD)
                    begin
                        if (hit && later)
                        begin
                            ram_wr_en = 1'b1;
                        end
                        if (chk_vld_reg && !valid_reg[chk_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = chk_idx_reg;
                        end
                    end
                    if (op_reg == FUNC_SWEEP && expired)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        any_exp_next            = 1'b1;
                    end
                    if (done)
                    begin
                        state_next   = S_IDLE;
                        chk_vld_next = 1'b0;
                    end
                    else if (rd_idx_reg < LAST_CNT)
                    begin
                        ram_rd_en    = 1'b1;
                        chk_vld_next = 1'b1;
                        chk_idx_next = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next  = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                        state_next   = S_END;
                    end
                end
            end
            S_END:
            begin
                if (load_ok)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{event_res:   EV_END,
                                       slot_index:  '0,
                                       entry_key:   '0,
                                       entry_kind:  1'b0,
                                       any_expired: 1'b0,
                                       last:        1'b1};
                    if (op_reg == FUNC_ADD)
                    begin
                        rsp_next.entry_key  = key_reg;
                        rsp_next.entry_kind = kind_reg;
                        if (free_found_reg)
                        begin
                            rsp_next.event_res      = EV_ADDED;
                            rsp_next.slot_index     = SLOT_W'(free_idx_reg);
                            ram_wr_en               = 1'b1;
                            ram_wr_addr             = free_idx_reg;
                            ram_wr_data             = '{key: key_reg, kind: kind_reg,
                                                        expiry: target_reg};
                            valid_next[free_idx_reg] = 1'b1;
                        end
                        else
                        begin
                            rsp_next.event_res = EV_FULL;
                        end
                    end
                    else
                    begin
                        rsp_next.any_expired = (op_reg == FUNC_SWEEP) && any_exp_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            chk_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            any_exp_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            rd_idx_reg     <= rd_idx_next;
            chk_vld_reg    <= chk_vld_next;
            free_found_reg <= free_found_next;
            any_exp_reg    <= any_exp_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == S_SCAN))
        else $error("slot check pending outside the walk");

    a_rd_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_idx_reg <= LAST_CNT)
        else $error("read index past the table");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg != S_IDLE && op_reg == FUNC_ADD))
        else $error("slot RAM written outside an add");

    a_added_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_END && op_reg == FUNC_ADD && free_found_reg && load_ok)
        |=> valid_reg[$past(free_idx_reg)])
        else $error("added slot not marked valid");

endmodule

`default_nettype wire
